### src/nps_pkg.sv
// Shared constants and command/status types for the priority scheduler.
// No dependencies; imported by nps_ctrl, nps_datapath and the top level.
`default_nettype none

package nps_pkg;

    localparam int ARR_W         = 16;
    localparam int BUR_W         = 16;
    localparam int PRI_W         = 8;
    localparam int NUM_W         = 5;
    localparam int TIME_W        = 21;
    localparam int ENTRY_W       = ARR_W + BUR_W + PRI_W;
    localparam int DEF_MAX_PROCS = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_wr;      // write the request into the job table
        logic scan_start;   // clear the best and earliest trackers
        logic cmp_en;       // table read data is valid for comparison
        logic jump;         // advance the clock to the earliest pending arrival
        logic pick;         // latch the finish time of the chosen job
        logic emit;         // load the result register, retire the job
        logic emit_last;    // this result closes the schedule
        logic batch_clear;  // drop done flags and clock for the next batch
    } nps_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic found;        // a ready job was seen in the last scan
        logic out_free;     // result register can take a new result
    } nps_sts_t;

endpackage

`default_nettype wire

### src/nps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

### src/nps_datapath.sv
// Datapath: job table, pick/earliest trackers, scheduler clock, done flags
// and result register. Depends on nps_pkg and nps_ram.
`default_nettype none

module nps_datapath #(
    parameter int MAX_PROCS = nps_pkg::DEF_MAX_PROCS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire nps_pkg::nps_cmd_t             cmd,
    output nps_pkg::nps_sts_t                  sts,
    input  wire logic [$clog2(MAX_PROCS)-1:0]  wr_addr,
    input  wire logic [$clog2(MAX_PROCS)-1:0]  rd_addr,
    input  wire logic [$clog2(MAX_PROCS)-1:0]  cmp_idx,
    input  wire logic [nps_pkg::ARR_W-1:0]     arrival_time,
    input  wire logic [nps_pkg::BUR_W-1:0]     burst_length,
    input  wire logic [nps_pkg::PRI_W-1:0]     job_priority,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [nps_pkg::NUM_W-1:0]     job_number,
    output logic      [nps_pkg::TIME_W-1:0]    start_time,
    output logic      [nps_pkg::TIME_W-1:0]    finish_time,
    output logic      [nps_pkg::TIME_W-1:0]    waiting_time,
    output logic      [nps_pkg::TIME_W-1:0]    response_time,
    output logic                               last_in_order
);

    import nps_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int JN_W  = (IDX_W + 1 > NUM_W) ? IDX_W + 1 : NUM_W;

    logic [ENTRY_W-1:0] rd_data;
    logic [ARR_W-1:0]   rd_arr;
    logic [BUR_W-1:0]   rd_bur;
    logic [PRI_W-1:0]   rd_pri;

    logic [TIME_W-1:0]  clock_reg,       clock_next;
    logic [MAX_PROCS-1:0] done_reg,      done_next;
    logic               best_found_reg,  best_found_next;
    logic [IDX_W-1:0]   best_idx_reg,    best_idx_next;
    logic [PRI_W-1:0]   best_pri_reg,    best_pri_next;
    logic [ARR_W-1:0]   best_arr_reg,    best_arr_next;
    logic [BUR_W-1:0]   best_bur_reg,    best_bur_next;
    logic               early_found_reg, early_found_next;
    logic [ARR_W-1:0]   early_arr_reg,   early_arr_next;
    logic [TIME_W-1:0]  finish_reg;
    logic               out_valid_reg,   out_valid_next;

    logic [NUM_W-1:0]   num_reg;
    logic [TIME_W-1:0]  start_reg, fin_out_reg, wait_reg, resp_reg;
    logic               last_reg;

    logic               entry_pending;
    logic               entry_ready;
    logic [TIME_W:0]    finish_sum;
    logic [TIME_W-1:0]  finish_sat;
    logic [ARR_W:0]     arr_bur;
    logic [TIME_W-1:0]  arr_bur_ext;
    logic [TIME_W-1:0]  wait_val;
    logic [TIME_W-1:0]  resp_val;
    logic [JN_W-1:0]    num_sum;

    nps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.load_wr),
        .wr_addr (wr_addr),
        .wr_data ({arrival_time, burst_length, job_priority}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_arr = rd_data[ENTRY_W-1 -: ARR_W];
    assign rd_bur = rd_data[PRI_W +: BUR_W];
    assign rd_pri = rd_data[PRI_W-1:0];

    assign entry_pending = !done_reg[cmp_idx];
    assign entry_ready   = entry_pending && (TIME_W'(rd_arr) <= clock_reg);

    // Saturating finish time of the chosen job
    assign finish_sum = (TIME_W+1)'(clock_reg) + (TIME_W+1)'(best_bur_reg);
    assign finish_sat = (finish_sum > (TIME_W+1)'(TIME_MAX)) ? TIME_MAX
                                                              : finish_sum[TIME_W-1:0];

    // Waiting time floors at zero once the clock has saturated
    assign arr_bur     = (ARR_W+1)'(best_arr_reg) + (ARR_W+1)'(best_bur_reg);
    assign arr_bur_ext = TIME_W'(arr_bur);
    assign wait_val    = (finish_reg >= arr_bur_ext) ? finish_reg - arr_bur_ext
                                                     : '0;
    assign resp_val    = clock_reg - TIME_W'(best_arr_reg);
    assign num_sum     = JN_W'(best_idx_reg) + JN_W'(1);

    always_comb
    begin
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_pri_next    = best_pri_reg;
        best_arr_next    = best_arr_reg;
        best_bur_next    = best_bur_reg;
        early_found_next = early_found_reg;
        early_arr_next   = early_arr_reg;
        clock_next       = clock_reg;
        done_next        = done_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (cmd.scan_start)
        begin
            best_found_next  = 1'b0;
            early_found_next = 1'b0;
        end
        else if (cmd.cmp_en)
        begin
            // Strict compare keeps the earlier-loaded job on a tie
            if (entry_ready && (!best_found_reg || rd_pri > best_pri_reg))
            begin
                best_found_next = 1'b1;
                best_idx_next   = cmp_idx;
                best_pri_next   = rd_pri;
                best_arr_next   = rd_arr;
                best_bur_next   = rd_bur;
            end
            if (entry_pending && (!early_found_reg || rd_arr < early_arr_reg))
            begin
                early_found_next = 1'b1;
                early_arr_next   = rd_arr;
            end
        end

        if (cmd.jump)
        begin
            clock_next = TIME_W'(early_arr_reg);
        end

        if (cmd.emit)
        begin
            clock_next              = finish_reg;
            done_next[best_idx_reg] = 1'b1;
            out_valid_next          = 1'b1;
        end

        if (cmd.batch_clear)
        begin
            clock_next = '0;
            done_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg       <= '0;
            done_reg        <= '0;
            best_found_reg  <= 1'b0;
            early_found_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            clock_reg       <= clock_next;
            done_reg        <= done_next;
            best_found_reg  <= best_found_next;
            early_found_reg <= early_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_pri_reg  <= best_pri_next;
        best_arr_reg  <= best_arr_next;
        best_bur_reg  <= best_bur_next;
        early_arr_reg <= early_arr_next;
        if (cmd.pick)
        begin
            finish_reg <= finish_sat;
        end
        if (cmd.emit)
        begin
            num_reg     <= num_sum[NUM_W-1:0];
            start_reg   <= clock_reg;
            fin_out_reg <= finish_reg;
            wait_reg    <= wait_val;
            resp_reg    <= resp_val;
            last_reg    <= cmd.emit_last;
        end
    end

    assign sts.found    = best_found_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign job_number    = num_reg;
    assign start_time    = start_reg;
    assign finish_time   = fin_out_reg;
    assign waiting_time  = wait_reg;
    assign response_time = resp_reg;
    assign last_in_order = last_reg;

endmodule

`default_nettype wire

### src/nps_ctrl.sv
// Controller: batch loading, table scan sequencing, pick and emit steps.
// Depends on nps_pkg.
`default_nettype none

module nps_ctrl #(
    parameter int MAX_PROCS = nps_pkg::DEF_MAX_PROCS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          last_job,
    output nps_pkg::nps_cmd_t                  cmd,
    input  wire nps_pkg::nps_sts_t             sts,
    output logic      [$clog2(MAX_PROCS)-1:0]  wr_addr,
    output logic      [$clog2(MAX_PROCS)-1:0]  rd_addr,
    output logic      [$clog2(MAX_PROCS)-1:0]  cmp_idx
);

    import nps_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]       state_reg,     state_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [CNT_W-1:0] left_reg,      left_next;
    logic [IDX_W-1:0] scan_idx_reg,  scan_idx_next;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    logic             in_acc;
    logic             room;
    logic             scan_end;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign room     = (count_reg < CNT_W'(MAX_PROCS));
    assign scan_end = (CNT_W'(scan_idx_reg) == count_reg - CNT_W'(1));

    assign wr_addr = count_reg[IDX_W-1:0];
    assign rd_addr = scan_idx_reg;
    assign cmp_idx = cmp_idx_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        scan_idx_next = scan_idx_reg;
        cmd           = '0;
        cmd.cmp_en    = cmp_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    // A full table drops the request but still honours last_job
                    if (room)
                    begin
                        cmd.load_wr = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    if (last_job)
                    begin
                        left_next      = count_next;
                        scan_idx_next  = '0;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.found)
                begin
                    cmd.pick   = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    // Nothing ready: jump to the earliest arrival and rescan
                    cmd.jump       = 1'b1;
                    cmd.scan_start = 1'b1;
                    scan_idx_next  = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = (left_reg == CNT_W'(1));
                    left_next     = left_reg - CNT_W'(1);
                    if (cmd.emit_last)
                    begin
                        cmd.batch_clear = 1'b1;
                        count_next      = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        scan_idx_next  = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            scan_idx_reg  <= scan_idx_next;
            // Table read data comes from a registered read, so the compare controls are delayed to match
            cmp_valid_reg <= (state_reg == ST_SCAN);
            cmp_idx_reg   <= scan_idx_reg;
        end
    end

endmodule

`default_nettype wire

### src/nonpreemptive_priority_scheduler_core.sv
// Top level of the non-preemptive priority scheduler.
// Depends on nps_pkg, nps_ctrl and nps_datapath.
//
//   Input channel (in_valid/in_ready) takes one job request per transfer:
//   arrival_time, burst_length, job_priority and last_job. Requests are
//   stored until one with last_job set closes the batch; at most MAX_PROCS
//   are held, later ones are dropped, and last_job still starts the run.
//   in_ready is high only while the block is collecting a batch.
//   Output channel (out_valid/out_ready) gives one result per job in run
//   order; last_in_order marks the final result of the schedule.
//   Timing: each decision scans the N loaded jobs through the job table's
//   single read port, one entry a cycle, then passes the drain and decide
//   states before a pick; a decision that finds no job ready jumps the
//   clock to the earliest pending arrival and rescans the table.
//   A stalled receiver holds the result register; the scan of the next
//   job continues and waits for the register to free before emitting.
//   Reset clears the batch count, done flags and scheduler clock; the job
//   table needs no clearing as only loaded entries are read.
`default_nettype none

module nonpreemptive_priority_scheduler_core #(
    parameter int MAX_PROCS = nps_pkg::DEF_MAX_PROCS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [nps_pkg::ARR_W-1:0]   arrival_time,
    input  wire logic [nps_pkg::BUR_W-1:0]   burst_length,
    input  wire logic [nps_pkg::PRI_W-1:0]   job_priority,
    input  wire logic                        last_job,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [nps_pkg::NUM_W-1:0]   job_number,
    output logic      [nps_pkg::TIME_W-1:0]  start_time,
    output logic      [nps_pkg::TIME_W-1:0]  finish_time,
    output logic      [nps_pkg::TIME_W-1:0]  waiting_time,
    output logic      [nps_pkg::TIME_W-1:0]  response_time,
    output logic                             last_in_order
);

    import nps_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCS);

    nps_cmd_t         cmd;
    nps_sts_t         sts;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] cmp_idx;

    nps_ctrl #(
        .MAX_PROCS (MAX_PROCS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .last_job (last_job),
        .cmd      (cmd),
        .sts      (sts),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .cmp_idx  (cmp_idx)
    );

    nps_datapath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .cmp_idx       (cmp_idx),
        .arrival_time  (arrival_time),
        .burst_length  (burst_length),
        .job_priority  (job_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .job_number    (job_number),
        .start_time    (start_time),
        .finish_time   (finish_time),
        .waiting_time  (waiting_time),
        .response_time (response_time),
        .last_in_order (last_in_order)
    );

    // Only a job found ready may be emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.found)
        else $error("emit without a ready job");

    // Saturation never lets a job finish before it starts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (finish_time >= start_time))
        else $error("finish earlier than start");

    // A job never starts before its arrival
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (response_time <= start_time))
        else $error("response exceeds start time");

    // Loading and emitting never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !in_ready)
        else $error("emit while collecting a batch");

endmodule

`default_nettype wire
